// File: rtl/fzn_pkg.sv
// Shared types and constants of the feature z-score normalizer.
// Used by every module of the block; depends on nothing.
package fzn_pkg;

  localparam int MAX_SAMPLES_DEF  = 16384;
  localparam int DIM_COUNT_DEF    = 4;
  localparam int NUM_LANES        = 4;
  localparam int FEAT_W           = 16;
  localparam int SAMPLE_W         = NUM_LANES * FEAT_W;

  // Shared divider: dividend covers the squared-deviation sum, divisor a count or a root.
  localparam int DIV_DW = 50;
  localparam int DIV_VW = 17;
  // Square root works on a 32-bit variance and gives a 17-bit rounded root.
  localparam int SQRT_W = 32;
  localparam int ROOT_W = 17;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EMIT = 1'b1;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] norm_0;
    logic signed [15:0] norm_1;
    logic signed [15:0] norm_2;
    logic signed [15:0] norm_3;
    logic [3:0]         flat_mask;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic       load;
    logic       mean_go;
    logic       mean_wr;
    logic       pass_step;
    logic       var_go;
    logic       sqrt_go;
    logic       inv_go;
    logic       inv_wr;
    logic       stats_set;
    logic       emit_rd;
    logic       emit_mul;
    logic       emit_out;
    logic [1:0] dim;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic stats_ready;
    logic pass_last;
    logic pass_busy;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } dp_stat_t;

endpackage

// File: rtl/feature_zscore_normalizer.sv
// Z-score normalizer top level. A load is taken without stalling the input. An emit with
// statistics ready reads the sample, multiplies and registers its result in S_EMIT_RD,
// S_EMIT_MUL and S_EMIT_OUT, holding the input stalled until the output is free.
// The first emit of a set first runs the statistics: per dimension a 50-step mean
// divide, one memory pass, then per dimension divide, 16-step square root, divide.
// Reset is synchronous and empties the set; the sample memory is not cleared.
module feature_zscore_normalizer #(
  parameter int MAX_SAMPLES  = fzn_pkg::MAX_SAMPLES_DEF,
  parameter int DIM_COUNT    = fzn_pkg::DIM_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fzn_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fzn_pkg::out_item_t  out_data
);

  fzn_pkg::dp_cmd_t  cmd;
  fzn_pkg::dp_stat_t stat;

  fzn_ctrl #(
    .DIM_COUNT (DIM_COUNT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  fzn_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .DIM_COUNT   (DIM_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/fzn_div.sv
// Restoring divider, one quotient bit per cycle, quotient held after done.
// Depends on fzn_pkg for its widths.
module fzn_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [fzn_pkg::DIV_DW-1:0]  dividend_i,
  input  logic [fzn_pkg::DIV_VW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [fzn_pkg::DIV_DW-1:0]  quot_o
);

  localparam int DW   = fzn_pkg::DIV_DW;
  localparam int VW   = fzn_pkg::DIV_VW;
  localparam int CNTW = $clog2(DW);
  localparam logic [CNTW-1:0] LAST_STEP = CNTW'(DW - 1);

  logic [DW-1:0]   quot_r, quot_nxt;
  logic [VW-1:0]   rem_r, rem_nxt;
  logic [VW-1:0]   dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r, done_r;
  logic [VW:0]     rem_sh, rem_sub;
  logic            ge;

  always_comb begin
    rem_sh   = {rem_r, quot_r[DW-1]};
    rem_sub  = rem_sh - {1'b0, dvs_r};
    ge       = (rem_sh >= {1'b0, dvs_r});
    rem_nxt  = ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
    quot_nxt = {quot_r[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        quot_r <= dividend_i;
        rem_r  <= '0;
        dvs_r  <= divisor_i;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        quot_r <= quot_nxt;
        rem_r  <= rem_nxt;
        cnt_r  <= cnt_r + CNTW'(1);
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_r;
  assign quot_o = quot_r;

endmodule

// File: rtl/fzn_sqrt.sv
// Bit-pair integer square root with round-to-nearest on the remainder.
// Depends on fzn_pkg for its widths.
module fzn_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start_i,
  input  logic [fzn_pkg::SQRT_W-1:0]  value_i,
  output logic                        done_o,
  output logic [fzn_pkg::ROOT_W-1:0]  root_o
);

  localparam int W = fzn_pkg::SQRT_W;
  localparam int RW = fzn_pkg::ROOT_W;

  logic [W-1:0] rem_r, res_r, bit_r;
  logic         busy_r, done_r;
  logic [W:0]   trial;
  logic         ge;

  always_comb begin
    trial = {1'b0, res_r} + {1'b0, bit_r};
    ge    = ({1'b0, rem_r} >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        rem_r  <= value_i;
        res_r  <= '0;
        bit_r  <= W'(1) << (W - 2);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (ge) begin
          rem_r <= rem_r - trial[W-1:0];
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[1:0] != 2'b00) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The remainder holds value - res^2, so rem > res means the root rounds up.
  assign root_o = res_r[RW-1:0] + RW'(rem_r > res_r);
  assign done_o = done_r;

endmodule

// File: rtl/fzn_datapath.sv
// Datapath: sample memory, per-dimension sums and statistics, the squared
// deviation lanes, the normalizing multipliers and the output register.
// Depends on fzn_pkg, fzn_div and fzn_sqrt.
module fzn_datapath #(
  parameter int MAX_SAMPLES  = fzn_pkg::MAX_SAMPLES_DEF,
  parameter int DIM_COUNT    = fzn_pkg::DIM_COUNT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fzn_pkg::in_item_t   in_data,
  input  fzn_pkg::dp_cmd_t    cmd,
  output fzn_pkg::dp_stat_t   stat,
  output logic                out_valid,
  input  logic                out_stall,
  output fzn_pkg::out_item_t  out_data
);

  localparam int NL = fzn_pkg::NUM_LANES;
  localparam int FW = fzn_pkg::FEAT_W;
  localparam int SW = fzn_pkg::SAMPLE_W;
  localparam int DW = fzn_pkg::DIV_DW;
  localparam int VW = fzn_pkg::DIV_VW;
  localparam int RW = fzn_pkg::ROOT_W;
  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SAMPLES);

  logic [SW-1:0] mem [MAX_SAMPLES];
  logic [SW-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] packed_in;
  logic [FW-1:0] feat [NL];

  logic [CW-1:0] count_r, ptr_r, pass_r, idx, count_m1, half_cnt;
  logic          stats_r, v1_r, v2_r, out_valid_r;
  logic          can_load, last;
  fzn_pkg::out_item_t out_data_r;

  logic signed [31:0] sum_r  [NL];
  logic signed [15:0] mean_r [NL];
  logic [31:0]        inv_r  [NL];
  logic [DW-1:0]      ssd_r  [NL];
  logic [33:0]        sq_r   [NL];
  logic [48:0]        prod_r [NL];
  logic               neg_r  [NL];

  logic signed [16:0] df  [NL];
  logic [16:0]        mag [NL];
  logic [FW-1:0]      norm [NL];
  logic [NL-1:0]      flat;

  logic               div_start, div_done, sqrt_done;
  logic [DW-1:0]      div_dividend, div_quot;
  logic [VW-1:0]      div_divisor;
  logic [RW-1:0]      root;
  logic signed [32:0] sum_sel;
  logic [32:0]        sum_mag;
  logic [15:0]        mean_q;
  logic [31:0]        inv_val;

  assign feat[0] = in_data.feature_0;
  assign feat[1] = in_data.feature_1;
  assign feat[2] = in_data.feature_2;
  assign feat[3] = in_data.feature_3;

  always_comb begin
    packed_in = '0;
    for (int d = 0; d < NL; d++) begin
      if (d < DIM_COUNT) packed_in[d*FW +: FW] = feat[d];
    end
  end

  assign count_m1 = count_r - CW'(1);
  assign half_cnt = count_r >> 1;
  assign idx      = (ptr_r < count_r) ? ptr_r : count_m1;
  assign last     = (({1'b0, idx} + (CW+1)'(1)) >= {1'b0, count_r});
  assign can_load = cmd.load && !stats_r && (count_r != MAX_CNT);
  assign rd_addr  = cmd.emit_rd ? idx[AW-1:0] : pass_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (can_load) mem[count_r[AW-1:0]] <= packed_in;
    rd_data_r <= mem[rd_addr];
  end

  // Deviation of the registered sample from each mean, as sign and magnitude.
  always_comb begin
    for (int d = 0; d < NL; d++) begin
      df[d]  = 17'(signed'(rd_data_r[d*FW +: FW])) - 17'(mean_r[d]);
      mag[d] = df[d][16] ? 17'(-df[d]) : 17'(df[d]);
    end
  end

  // Shared divider operand selection.
  always_comb begin
    sum_sel      = 33'(sum_r[cmd.dim]);
    sum_mag      = sum_sel[32] ? 33'(-sum_sel) : 33'(sum_sel);
    div_start    = cmd.mean_go | cmd.var_go | cmd.inv_go;
    div_dividend = DW'(sum_mag) + DW'(half_cnt);
    div_divisor  = VW'(count_r);
    if (cmd.var_go) begin
      div_dividend = ssd_r[cmd.dim] + DW'(half_cnt);
    end else if (cmd.inv_go) begin
      div_dividend = (DW'(1) << 32) + DW'(root >> 1);
      div_divisor  = VW'(root);
    end
    mean_q  = sum_r[cmd.dim][31] ? 16'(-div_quot[15:0]) : div_quot[15:0];
    inv_val = (div_quot[DW-1:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
    if (root == '0) inv_val = '0;
  end

  fzn_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  fzn_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd.sqrt_go),
    .value_i (div_quot[fzn_pkg::SQRT_W-1:0]),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // Rounding and saturation of the registered products.
  always_comb begin
    logic [49:0] rnd;
    logic [29:0] rq;
    for (int d = 0; d < NL; d++) begin
      rnd     = 50'(prod_r[d]) + (50'(1) << 19);
      rq      = rnd[49:20];
      flat[d] = (d < DIM_COUNT) && (inv_r[d] == '0);
      if (!(d < DIM_COUNT) || flat[d]) begin
        norm[d] = '0;
      end else if (neg_r[d]) begin
        norm[d] = (rq > 30'd32768) ? 16'h8000 : 16'(-rq[15:0]);
      end else begin
        norm[d] = (rq > 30'd32767) ? 16'h7FFF : rq[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      pass_r      <= '0;
      stats_r     <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int d = 0; d < NL; d++) begin
        sum_r[d]  <= '0;
        mean_r[d] <= '0;
        inv_r[d]  <= '0;
      end
    end else begin
      v1_r <= cmd.pass_step;
      v2_r <= v1_r;
      if (can_load) begin
        count_r <= count_r + CW'(1);
        for (int d = 0; d < NL; d++) begin
          if (d < DIM_COUNT) sum_r[d] <= sum_r[d] + 32'(signed'(feat[d]));
        end
      end
      if (cmd.mean_go) begin
        pass_r <= '0;
        for (int d = 0; d < NL; d++) ssd_r[d] <= '0;
      end
      if (cmd.mean_wr) mean_r[cmd.dim] <= mean_q;
      if (cmd.pass_step) pass_r <= pass_r + CW'(1);
      for (int d = 0; d < NL; d++) begin
        if (d < DIM_COUNT) begin
          if (v1_r) sq_r[d] <= mag[d] * mag[d];
          if (v2_r) ssd_r[d] <= ssd_r[d] + DW'(sq_r[d]);
        end
      end
      if (cmd.inv_wr) inv_r[cmd.dim] <= inv_val;
      if (cmd.stats_set) begin
        stats_r <= 1'b1;
        ptr_r   <= '0;
      end
      if (cmd.emit_mul) begin
        for (int d = 0; d < NL; d++) begin
          prod_r[d] <= mag[d] * inv_r[d];
          neg_r[d]  <= df[d][16];
        end
      end
      if (cmd.emit_out) begin
        out_valid_r            <= 1'b1;
        out_data_r.norm_0      <= norm[0];
        out_data_r.norm_1      <= norm[1];
        out_data_r.norm_2      <= norm[2];
        out_data_r.norm_3      <= norm[3];
        out_data_r.flat_mask   <= flat;
        out_data_r.last_of_run <= last;
        if (last) begin
          // End of the set: count, pointer, statistics flag, sums, means and inverses are cleared.
          count_r <= '0;
          ptr_r   <= '0;
          stats_r <= 1'b0;
          for (int d = 0; d < NL; d++) begin
            sum_r[d]  <= '0;
            mean_r[d] <= '0;
            inv_r[d]  <= '0;
          end
        end else begin
          ptr_r <= idx + CW'(1);
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.count_zero  = (count_r == '0);
  assign stat.stats_ready = stats_r;
  assign stat.pass_last   = (pass_r == count_m1);
  assign stat.pass_busy   = v1_r | v2_r;
  assign stat.div_done    = div_done;
  assign stat.sqrt_done   = sqrt_done;
  assign stat.out_free    = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/fzn_ctrl.sv
// Controller: sequences loads, the mean, deviation-pass and inverse phases and each readout.
// Depends on fzn_pkg for the command and status structs.
module fzn_ctrl #(
  parameter int DIM_COUNT = fzn_pkg::DIM_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_stall,
  input  fzn_pkg::dp_stat_t stat,
  output fzn_pkg::dp_cmd_t  cmd
);

  localparam logic [1:0] LAST_DIM = 2'(DIM_COUNT - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MEAN_GO, S_MEAN_WAIT, S_MEAN_WR, S_SSD_RUN, S_SSD_DRAIN,
    S_VAR_GO, S_VAR_WAIT, S_SQRT_GO, S_SQRT_WAIT, S_INV_GO, S_INV_WAIT,
    S_INV_WR, S_EMIT_RD, S_EMIT_MUL, S_EMIT_OUT
  } state_t;

  state_t     state_r;
  logic [1:0] dim_r;
  logic       take;

  assign take     = (state_r == S_IDLE) && in_valid;
  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      dim_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          dim_r <= '0;
          if (take && in_kind == fzn_pkg::KIND_EMIT && !stat.count_zero) begin
            state_r <= stat.stats_ready ? S_EMIT_RD : S_MEAN_GO;
          end
        end
        S_MEAN_GO:   state_r <= S_MEAN_WAIT;
        S_MEAN_WAIT: if (stat.div_done) state_r <= S_MEAN_WR;
        S_MEAN_WR: begin
          if (dim_r == LAST_DIM) begin
            dim_r   <= '0;
            state_r <= S_SSD_RUN;
          end else begin
            dim_r   <= dim_r + 2'd1;
            state_r <= S_MEAN_GO;
          end
        end
        S_SSD_RUN:   if (stat.pass_last) state_r <= S_SSD_DRAIN;
        S_SSD_DRAIN: if (!stat.pass_busy) state_r <= S_VAR_GO;
        S_VAR_GO:    state_r <= S_VAR_WAIT;
        S_VAR_WAIT:  if (stat.div_done) state_r <= S_SQRT_GO;
        S_SQRT_GO:   state_r <= S_SQRT_WAIT;
        S_SQRT_WAIT: if (stat.sqrt_done) state_r <= S_INV_GO;
        S_INV_GO:    state_r <= S_INV_WAIT;
        S_INV_WAIT:  if (stat.div_done) state_r <= S_INV_WR;
        S_INV_WR: begin
          if (dim_r == LAST_DIM) begin
            state_r <= S_EMIT_RD;
          end else begin
            dim_r   <= dim_r + 2'd1;
            state_r <= S_VAR_GO;
          end
        end
        S_EMIT_RD:  state_r <= S_EMIT_MUL;
        S_EMIT_MUL: state_r <= S_EMIT_OUT;
        S_EMIT_OUT: if (stat.out_free) state_r <= S_IDLE;
        default:    state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.dim       = dim_r;
    cmd.load      = take && (in_kind == fzn_pkg::KIND_LOAD);
    cmd.mean_go   = (state_r == S_MEAN_GO);
    cmd.mean_wr   = (state_r == S_MEAN_WR);
    cmd.pass_step = (state_r == S_SSD_RUN);
    cmd.var_go    = (state_r == S_VAR_GO);
    cmd.sqrt_go   = (state_r == S_SQRT_GO);
    cmd.inv_go    = (state_r == S_INV_GO);
    cmd.inv_wr    = (state_r == S_INV_WR);
    cmd.stats_set = (state_r == S_INV_WR) && (dim_r == LAST_DIM);
    cmd.emit_rd   = (state_r == S_EMIT_RD);
    cmd.emit_mul  = (state_r == S_EMIT_MUL);
    cmd.emit_out  = (state_r == S_EMIT_OUT) && stat.out_free;
  end

endmodule

// File: rtl/fzn_checker.sv
// Port-level checks of the z-score normalizer, bound to the top level.
// Depends on fzn_pkg and feature_zscore_normalizer.
module fzn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input fzn_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input fzn_pkg::out_item_t out_data
);

  // A stalled result holds until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A load never starts any multi-cycle work.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == fzn_pkg::KIND_LOAD |=> !in_stall)
    else $error("input stalled after a load");

  // A new result appears only at the end of a busy readout, which then frees the input.
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall) && !in_stall)
    else $error("result appeared outside a readout");

  // A flat dimension always reads as zero.
  a_flat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.flat_mask[0] || out_data.norm_0 == 16'sd0) &&
                  (!out_data.flat_mask[1] || out_data.norm_1 == 16'sd0) &&
                  (!out_data.flat_mask[2] || out_data.norm_2 == 16'sd0) &&
                  (!out_data.flat_mask[3] || out_data.norm_3 == 16'sd0))
    else $error("flat dimension with nonzero value");

endmodule

bind feature_zscore_normalizer fzn_checker u_fzn_checker (.*);

// File: verif/testbench.sv
// Self-checking testbench for feature_zscore_normalizer: loads sample sets, requests
// normalized samples and compares each transfer with a bit-accurate predictor.
// Depends on rtl/fzn_pkg.sv and rtl/feature_zscore_normalizer.sv.
`timescale 1ns / 100ps

module testbench;

  localparam int STORE_DEPTH = fzn_pkg::MAX_SAMPLES_DEF;
  localparam int IDLE_LIMIT  = 200000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  fzn_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  fzn_pkg::out_item_t out_data;

  feature_zscore_normalizer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Predictor state, mirrors the block's set bookkeeping.
  logic [63:0]        sample_mem [STORE_DEPTH];
  int unsigned        set_count;
  int unsigned        set_ptr;
  logic signed [31:0] run_sum [4];
  logic signed [31:0] dim_avg [4];
  logic [31:0]        inv_sd [4];
  bit                 stats_valid;

  fzn_pkg::out_item_t norm_expected [$];
  fzn_pkg::in_item_t  pending_items [$];
  int        mismatch_count = 0;
  int        result_count = 0;
  int        load_count = 0;
  int        emit_count = 0;
  int        flat_count = 0;
  int        sat_count = 0;
  int        idle_cycles;
  bit        hold_req;
  int        gap_left;

  function automatic logic [63:0] root_rounded(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] b;
    root = 0;
    rem = v;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    if (rem > root) root = root + 1;
    return root;
  endfunction

  function automatic logic signed [15:0] lane_of(logic [63:0] s, int d);
    return s[16*d +: 16];
  endfunction

  function automatic void queue_item(fzn_pkg::in_item_t it);
    pending_items = {pending_items, it};
  endfunction

  task automatic clear_stats();
    set_count = 0;
    set_ptr = 0;
    stats_valid = 0;
    for (int d = 0; d < 4; d++) begin
      run_sum[d] = 0;
      dim_avg[d] = 0;
      inv_sd[d] = 0;
    end
  endtask

  task automatic freeze_stats();
    logic [63:0] n;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] ssd;
    logic [63:0] a;
    logic [63:0] sd;
    logic [63:0] inv;
    longint      df;
    n = set_count;
    for (int d = 0; d < 4; d++) begin
      mag = run_sum[d] < 0 ? 64'(-longint'(run_sum[d])) : 64'(run_sum[d]);
      q = (mag + n / 2) / n;
      dim_avg[d] = run_sum[d] < 0 ? -32'(q) : 32'(q);
      ssd = 0;
      for (int i = 0; i < set_count; i++) begin
        df = longint'(lane_of(sample_mem[i], d)) - longint'(dim_avg[d]);
        a = df < 0 ? 64'(-df) : 64'(df);
        ssd = ssd + a * a;
      end
      sd = root_rounded((ssd + n / 2) / n);
      if (sd == 0) begin
        inv_sd[d] = 0;
      end else begin
        inv = ((64'd1 << 32) + sd / 2) / sd;
        inv_sd[d] = inv > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : inv[31:0];
      end
    end
    stats_valid = 1;
    set_ptr = 0;
  endtask

  task automatic predict_transfer(fzn_pkg::in_item_t it);
    logic [63:0]        smp;
    logic signed [15:0] lane [4];
    logic [3:0]         flat;
    logic [63:0]        a;
    logic [63:0]        q;
    longint             df;
    fzn_pkg::out_item_t r;
    int unsigned        idx;
    if (it.kind == fzn_pkg::KIND_LOAD) begin
      load_count++;
      if (stats_valid || set_count >= STORE_DEPTH) return;
      sample_mem[set_count] = {it.feature_3, it.feature_2, it.feature_1, it.feature_0};
      run_sum[0] = run_sum[0] + it.feature_0;
      run_sum[1] = run_sum[1] + it.feature_1;
      run_sum[2] = run_sum[2] + it.feature_2;
      run_sum[3] = run_sum[3] + it.feature_3;
      set_count++;
      return;
    end
    emit_count++;
    if (set_count == 0) return;
    if (!stats_valid) freeze_stats();
    idx = set_ptr < set_count ? set_ptr : set_count - 1;
    smp = sample_mem[idx];
    flat = 0;
    for (int d = 0; d < 4; d++) begin
      lane[d] = 0;
      if (inv_sd[d] == 0) begin
        flat[d] = 1'b1;
      end else begin
        df = longint'(lane_of(smp, d)) - longint'(dim_avg[d]);
        a = df < 0 ? 64'(-df) : 64'(df);
        q = (a * inv_sd[d] + (64'd1 << 19)) >> 20;
        if (df < 0) lane[d] = q > 32768 ? -16'sd32768 : -16'(q);
        else lane[d] = q > 32767 ? 16'sd32767 : 16'(q);
        if (q > 32767) sat_count++;
      end
    end
    if (flat != 0) flat_count++;
    r.norm_0 = lane[0];
    r.norm_1 = lane[1];
    r.norm_2 = lane[2];
    r.norm_3 = lane[3];
    r.flat_mask = flat;
    r.last_of_run = (idx + 1 >= set_count);
    norm_expected = {norm_expected, r};
    if (r.last_of_run) clear_stats();
    else set_ptr = idx + 1;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: one item per transfer; valid stays up across back-to-back items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap_left <= 0;
      clear_stats();
    end else if (in_valid && !in_stall) begin
      predict_transfer(in_data);
      if (pending_items.size() != 0 && !hold_req && pick_gap() == 0) begin
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
        gap_left <= pick_gap();
      end
    end else if (!in_valid) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0 && !hold_req) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver stall pattern, with occasional long hold-offs counted here.
  int stall_left;
  int long_hold;
  bit force_long_hold;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      long_hold <= 0;
    end else if (force_long_hold && long_hold == 0 && stall_left == 0) begin
      long_hold <= 300;
      out_stall <= 1'b1;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
      out_stall <= long_hold > 1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= stall_left > 1;
    end else if ($urandom_range(0, 99) < 20) begin
      stall_left <= pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor and scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      result_count++;
      if (norm_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result transfer: %p", out_data);
      end else begin
        fzn_pkg::out_item_t e;
        e = norm_expected.pop_front();
        if (e !== out_data) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d mismatch: expected %p, got %p", result_count, e, out_data);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog expired");
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  function automatic fzn_pkg::in_item_t make_load(logic signed [15:0] f0,
                                                  logic signed [15:0] f1,
                                                  logic signed [15:0] f2,
                                                  logic signed [15:0] f3);
    fzn_pkg::in_item_t it;
    it.kind = fzn_pkg::KIND_LOAD;
    it.feature_0 = f0;
    it.feature_1 = f1;
    it.feature_2 = f2;
    it.feature_3 = f3;
    return it;
  endfunction

  function automatic fzn_pkg::in_item_t make_emit();
    fzn_pkg::in_item_t it;
    it = make_load(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    it.kind = fzn_pkg::KIND_EMIT;
    return it;
  endfunction

  function automatic logic signed [15:0] rand_feature(int style, logic signed [15:0] base);
    case (style)
      0: return 16'($urandom);
      1: return base + 16'($urandom_range(0, 64)) - 16'sd32;
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return base;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || norm_expected.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    int n;
    int style [4];
    logic signed [15:0] base [4];
    rst_n = 1'b0;
    hold_req = 0;
    force_long_hold = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: emit on empty store, a flat single sample, extremes, readout loads.
    queue_item(make_emit());
    queue_item(make_load(16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF));
    queue_item(make_emit());
    queue_item(make_load(16'sh7FFF, 16'sh8000, 16'sh0001, 16'sh1234));
    queue_item(make_load(16'sh8000, 16'sh7FFF, 16'sh0001, 16'sh1234));
    queue_item(make_load(16'sh7FFF, 16'sh7FFF, 16'sh0001, 16'sh1235));
    queue_item(make_emit());
    queue_item(make_load(16'sh5555, 16'shAAAA, 16'sh0F0F, 16'shF0F0));
    queue_item(make_emit());
    queue_item(make_emit());
    queue_item(make_emit());
    // Tiny spread with one outlier drives the outlier's norms to their largest values.
    for (int i = 0; i < 12; i++)
      queue_item(make_load(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
    queue_item(make_load(16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF));
    for (int i = 0; i < 13; i++) queue_item(make_emit());
    wait_drained();

    // Long receiver hold-off while emits pile up.
    for (int i = 0; i < 20; i++)
      queue_item(make_load(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)));
    for (int i = 0; i < 20; i++) queue_item(make_emit());
    force_long_hold = 1;
    wait (long_hold != 0);
    force_long_hold = 0;
    wait_drained();

    // Random sets: mostly load-then-readout sequences, some noise.
    while (load_count + emit_count < 2000) begin
      n = $urandom_range(0, 19) == 0 ? $urandom_range(100, 300) : $urandom_range(1, 24);
      for (int d = 0; d < 4; d++) begin
        style[d] = $urandom_range(0, 3);
        base[d] = 16'($urandom);
      end
      for (int i = 0; i < n; i++) begin
        queue_item(make_load(rand_feature(style[0], base[0]),
                             rand_feature(style[1], base[1]),
                             rand_feature(style[2], base[2]),
                             rand_feature(style[3], base[3])));
        if ($urandom_range(0, 29) == 0) queue_item(make_emit());
      end
      for (int i = 0; i < n + 2; i++) begin
        if ($urandom_range(0, 9) == 0)
          queue_item(make_load(16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom)));
        queue_item(make_emit());
      end
      if ($urandom_range(0, 9) == 0) begin
        force_long_hold = 1;
        wait (long_hold != 0);
        force_long_hold = 0;
      end
      while (pending_items.size() > 8) @(posedge clk);
    end
    wait_drained();
    repeat (50) @(posedge clk);

    $display("ran %0d loads and %0d emits, checked %0d normalized samples", load_count,
             emit_count, result_count);
    $display("%0d results had a flat dimension, %0d lanes saturated", flat_count, sat_count);
    if (mismatch_count == 0 && norm_expected.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results still expected", mismatch_count,
               norm_expected.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
